// File: hdl/ssbp_pkg.sv
package ssbp_pkg;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV,
      ST_PART,
      ST_SRCH_RD,
      ST_SRCH_CMP,
      ST_SCAN_RD,
      ST_SCAN_CMP,
      ST_EMIT
   } state_type;

   localparam logic [1:0] CSR_TOTAL_LENGTH   = 2'd0;
   localparam logic [1:0] CSR_NUM_SEQUENCES  = 2'd1;
   localparam logic [1:0] CSR_NUM_PARTS      = 2'd2;
   localparam logic [1:0] CSR_UNIFORM_LENGTH = 2'd3;

   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_RUN  = 1'b1;

endpackage

// File: hdl/ssbp_divider.sv
module ssbp_divider #(
   parameter int WIDTH = 32,
   parameter int DWIDTH = 7
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [WIDTH-1:0]  dividend,
   input  logic [DWIDTH-1:0] divisor,
   output logic              done,
   output logic [WIDTH-1:0]  quotient
);
   localparam int CW = $clog2(WIDTH + 1);

   logic [WIDTH-1:0]  q_ff, q_in;
   logic [DWIDTH:0]   r_ff, r_in;
   logic [DWIDTH-1:0] d_ff, d_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic [DWIDTH:0]   shifted;

   always_comb begin
      q_in = q_ff;
      r_in = r_ff;
      d_in = d_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      shifted = {r_ff[DWIDTH-1:0], q_ff[WIDTH-1]};
      if (start) begin
         q_in = dividend;
         r_in = '0;
         d_in = divisor;
         cnt_in = CW'(WIDTH);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (shifted >= {1'b0, d_ff}) begin
            r_in = shifted - {1'b0, d_ff};
            q_in = {q_ff[WIDTH-2:0], 1'b1};
         end else begin
            r_in = shifted;
            q_in = {q_ff[WIDTH-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      r_ff <= r_in;
      d_ff <= d_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   assign done = busy_ff && (cnt_ff == CW'(1));
   assign quotient = q_in;
endmodule

// File: hdl/sequence_set_balanced_partitioner_top.sv
// Run steps: the divide, then per part a setup state, binary search read and compare steps
//   (about log2(num_sequences)+1 steps, none when each sequence is its own part), a scan
//   read and compare per sequence and an emit state.
// Throughput: one load beat per cycle when idle; busy is high from run start to its last beat.
// Reset clears configuration to defaults and the load count; the table is undefined until loaded.
// Results appear for one cycle on rsp_valid; the receiver cannot stall.
module sequence_set_balanced_partitioner_top #(
   parameter int MAX_SEQS = 4096,
   parameter int MAX_PARTS = 64,
   parameter int POS_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_kind,
   input  logic [31:0] req_separator_pos,
   output logic        rsp_valid,
   output logic [5:0]  rsp_part_index,
   output logic [11:0] rsp_first_seq,
   output logic [11:0] rsp_last_seq,
   output logic [31:0] rsp_longest,
   output logic        rsp_is_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);
   import ssbp_pkg::*;

   localparam int DEPTH = MAX_SEQS - 1;
   localparam int SW = $clog2(MAX_SEQS + 1);
   localparam int AW = $clog2(DEPTH);
   localparam int PW = $clog2(MAX_PARTS + 1);
   localparam int PIW = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1;

   logic [31:0] total_ff, uni_ff;
   logic [12:0] nseq_ff;
   logic [6:0]  npart_ff;
   logic [SW-1:0] load_ff;

   logic [POS_WIDTH-1:0] mem [DEPTH];
   logic [POS_WIDTH-1:0] rd_a_ff, rd_b_ff;
   logic [AW-1:0] addr_a, addr_b;

   state_type st_ff, st_in;
   logic [SW-1:0] ns_ff, s_ff, first_ff, lo_ff, hi_ff, mid_ff, hit_ff, last_ff;
   logic [PW-1:0] np_ff, cnt_ff;
   logic got_ff, single_ff;
   logic [POS_WIDTH-1:0] width_ff, base_ff, best_ff;

   logic [SW-1:0] ns_c;
   logic [PW-1:0] np_c;
   logic div_done;
   logic [POS_WIDTH-1:0] div_q;

   logic [POS_WIDTH-1:0] u1, tl;
   logic [SW-1:0] sq_s;
   logic [POS_WIDTH-1:0] sq_start, sq_end;
   logic [POS_WIDTH-1:0] mul_s, mul_s1;

   assign csr_ready = 1'b1;
   assign busy = (st_ff != ST_IDLE);

   always_comb begin
      ns_c = SW'(nseq_ff);
      if (nseq_ff == 13'd0) ns_c = SW'(1);
      if (32'(nseq_ff) > 32'(MAX_SEQS)) ns_c = SW'(MAX_SEQS);
      np_c = PW'(npart_ff);
      if (npart_ff == 7'd0) np_c = PW'(1);
      if (32'(npart_ff) > 32'(MAX_PARTS)) np_c = PW'(MAX_PARTS);
   end

   ssbp_divider #(.WIDTH(POS_WIDTH), .DWIDTH(PW)) u_div (
      .clock(clock), .reset(reset),
      .start(start && !busy && req_kind == KIND_RUN),
      .dividend(POS_WIDTH'(total_ff)), .divisor(np_c),
      .done(div_done), .quotient(div_q)
   );

   // sequence geometry for sq_s; table words come from registered reads
   assign u1 = POS_WIDTH'(uni_ff) + POS_WIDTH'(1);
   assign tl = POS_WIDTH'(total_ff);
   assign sq_s = (st_ff == ST_SRCH_CMP) ? mid_ff : s_ff;
   assign mul_s = POS_WIDTH'(sq_s) * u1;
   assign mul_s1 = mul_s + u1;
   always_comb begin
      if (uni_ff != 32'd0) begin
         sq_start = mul_s;
         sq_end = mul_s1 - POS_WIDTH'(2);
      end else begin
         sq_start = (sq_s == '0) ? '0 : rd_a_ff + POS_WIDTH'(1);
         sq_end = (sq_s + SW'(1) < ns_ff) ? rd_b_ff - POS_WIDTH'(1) : tl - POS_WIDTH'(1);
      end
   end

   always_comb begin
      addr_a = AW'(sq_s - SW'(1));
      addr_b = AW'(sq_s);
      if (st_ff == ST_SRCH_RD || st_ff == ST_PART || st_ff == ST_SRCH_CMP) begin
         addr_a = AW'(first_ff - SW'(1));
         addr_b = AW'(mid_ff);
      end
      if (st_ff == ST_SCAN_RD) begin
         addr_a = AW'(s_ff - SW'(1));
         addr_b = AW'(s_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy && req_kind == KIND_LOAD && 32'(load_ff) < 32'(DEPTH)) begin
         mem[AW'(load_ff)] <= POS_WIDTH'(req_separator_pos);
      end
      rd_a_ff <= mem[addr_a];
      rd_b_ff <= mem[addr_b];
   end

   logic wider;
   assign wider = (sq_end - base_ff) > width_ff;

   logic search_end;
   logic [SW-1:0] lo_n, hi_n, hit_n;
   logic got_n, brk;
   always_comb begin
      lo_n = lo_ff;
      hi_n = hi_ff;
      hit_n = hit_ff;
      got_n = got_ff;
      brk = 1'b0;
      if (wider) begin
         hit_n = mid_ff;
         got_n = 1'b1;
         if (hi_ff == '0 || mid_ff == '0) brk = 1'b1;
         hi_n = mid_ff - SW'(1);
      end else begin
         if (lo_ff == ns_ff - SW'(1)) brk = 1'b1;
         lo_n = mid_ff + SW'(1);
      end
      search_end = brk || (lo_n > hi_n);
   end

   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         ST_IDLE: if (start && req_kind == KIND_RUN) st_in = ST_DIV;
         ST_DIV: if (div_done) st_in = ST_PART;
         ST_PART: st_in = single_ff ? ST_SCAN_RD : ST_SRCH_RD;
         ST_SRCH_RD: st_in = ST_SRCH_CMP;
         ST_SRCH_CMP: st_in = search_end ? ST_SCAN_RD : ST_SRCH_RD;
         ST_SCAN_RD: st_in = ST_SCAN_CMP;
         ST_SCAN_CMP: st_in = (s_ff == last_ff) ? ST_EMIT : ST_SCAN_RD;
         ST_EMIT: st_in = rsp_is_last ? ST_IDLE : ST_PART;
         default: st_in = ST_IDLE;
      endcase
   end

   logic [SW-1:0] last_n;
   logic run_last;
   always_comb begin
      last_n = got_n ? hit_n : ns_ff - SW'(1);
      run_last = !got_n || (cnt_ff + PW'(1) == np_ff) || (last_n == ns_ff - SW'(1));
      if (run_last) last_n = ns_ff - SW'(1);
   end

   always_ff @(posedge clock) begin
      unique case (st_ff)
         ST_IDLE: begin
            ns_ff <= ns_c;
            np_ff <= np_c;
            single_ff <= (32'(np_c) >= 32'(ns_c));
            cnt_ff <= '0;
            first_ff <= '0;
         end
         ST_DIV: width_ff <= div_q;
         ST_PART: begin
            lo_ff <= first_ff;
            hi_ff <= ns_ff - SW'(1);
            mid_ff <= first_ff + ((ns_ff - SW'(1) - first_ff + SW'(1)) >> 1);
            got_ff <= 1'b0;
            s_ff <= first_ff;
            best_ff <= '0;
            last_ff <= first_ff;
         end
         ST_SRCH_RD: begin
            s_ff <= first_ff;
            base_ff <= sq_start;
         end
         ST_SRCH_CMP: begin
            lo_ff <= lo_n;
            hi_ff <= hi_n;
            hit_ff <= hit_n;
            got_ff <= got_n;
            mid_ff <= lo_n + ((hi_n - lo_n + SW'(1)) >> 1);
            if (search_end) begin
               last_ff <= last_n;
               s_ff <= first_ff;
            end
         end
         ST_SCAN_RD: ;
         ST_SCAN_CMP: begin
            if ((sq_end - sq_start + POS_WIDTH'(1)) > best_ff)
               best_ff <= sq_end - sq_start + POS_WIDTH'(1);
            s_ff <= s_ff + SW'(1);
         end
         ST_EMIT: begin
            cnt_ff <= cnt_ff + PW'(1);
            first_ff <= last_ff + SW'(1);
         end
         default: ;
      endcase
   end

   logic [PIW-1:0] pidx;
   assign pidx = PIW'(cnt_ff);
   assign rsp_valid = (st_ff == ST_EMIT);
   assign rsp_part_index = 6'(pidx);
   assign rsp_first_seq = 12'(first_ff);
   assign rsp_last_seq = 12'(last_ff);
   assign rsp_longest = 32'(best_ff);
   assign rsp_is_last = single_ff ? (last_ff == ns_ff - SW'(1))
                                  : (last_ff == ns_ff - SW'(1));

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
         total_ff <= 32'd1;
         nseq_ff <= 13'd1;
         npart_ff <= 7'd1;
         uni_ff <= 32'd0;
         load_ff <= '0;
      end else begin
         st_ff <= st_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_TOTAL_LENGTH: total_ff <= csr_data;
               CSR_NUM_SEQUENCES: nseq_ff <= csr_data[12:0];
               CSR_NUM_PARTS: npart_ff <= csr_data[6:0];
               CSR_UNIFORM_LENGTH: uni_ff <= csr_data;
               default: ;
            endcase
         end
         if (start && !busy && req_kind == KIND_LOAD && 32'(load_ff) < 32'(DEPTH))
            load_ff <= load_ff + SW'(1);
         else if (rsp_valid && rsp_is_last) load_ff <= '0;
      end
   end
endmodule
